FILE: rtl/c8spr_pkg.sv
// Shared constants, types and lookup tables for the packed-cell sprite engine.
`timescale 1ns / 1ps

package c8spr_pkg;

    // Screen geometry in pixels
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;

    // 2x2 pixel cells; an odd edge still gets a cell of its own
    localparam int CELL_COLS  = (SCREEN_WIDTH + 1) / 2;
    localparam int CELL_ROWS  = (SCREEN_HEIGHT + 1) / 2;
    localparam int CELL_COUNT = CELL_COLS * CELL_ROWS;

    localparam int X_W     = $clog2(SCREEN_WIDTH);
    localparam int Y_W     = $clog2(SCREEN_HEIGHT);
    localparam int COL_W   = $clog2(CELL_COLS);
    localparam int CADDR_W = $clog2(CELL_COUNT);

    // Port field widths
    localparam int POS_W  = 8;
    localparam int ROW_W  = 4;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 9;
    localparam int VAL_W  = 4;

    localparam int PIX_PER_ROW = 8;
    localparam int POS_VALUES  = 256;

    // Operation codes
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_DRAW  = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load_draw;   // latch a draw word
        logic load_clear;  // emit the clear result, restart the sweep
        logic sweep;       // write zero to one cell of the store
        logic wr_cell;     // update one cell and emit it
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic sweep_done;  // sweep is on the final cell
        logic last_cell;   // current cell is the last of the row
    } t_sta;

    typedef logic [X_W-1:0] t_xmod_tab [POS_VALUES];
    typedef logic [Y_W-1:0] t_ymod_tab [POS_VALUES];

    function automatic t_xmod_tab f_xmod_tab();
        t_xmod_tab tab;
        for (int i = 0; i < POS_VALUES; i++) begin
            tab[i] = X_W'(i % SCREEN_WIDTH);
        end
        return tab;
    endfunction

    function automatic t_ymod_tab f_ymod_tab();
        t_ymod_tab tab;
        for (int i = 0; i < POS_VALUES; i++) begin
            tab[i] = Y_W'(i % SCREEN_HEIGHT);
        end
        return tab;
    endfunction

    localparam t_xmod_tab XMOD_TAB = f_xmod_tab();
    localparam t_ymod_tab YMOD_TAB = f_ymod_tab();

endpackage

FILE: rtl/chip8_sprite_xor_packed_cells.sv
// Top level of the packed-cell sprite XOR engine with collision detection.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// command   in         start high, busy low        i_operation, i_x_position,
//                                                  i_y_position, i_row_offset,
//                                                  i_row_byte, i_first_row
// result    out        o_strobe, one cycle         o_cell_index, o_cell_value,
//                                                  o_collision, o_last
//
// A draw word holds busy through the read state and one write per cell: four
// cells for an even x, five for an odd x. The cell store is the limit: one
// read-modify-write per cell per cycle, the next cell read overlapping the
// current write; a new word is taken only once the last cell is written.
// A clear word emits its result at once, then sweeps zeros through all 512
// cells, one per cycle, and holds busy until the sweep is done.
// After reset the same sweep runs before the first word is taken.
// Results are registered as the cell is written; the receiver cannot
// stall, so each strobe is seen once only.

module chip8_sprite_xor_packed_cells (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_operation,
    input  logic [c8spr_pkg::POS_W-1:0]      i_x_position,
    input  logic [c8spr_pkg::POS_W-1:0]      i_y_position,
    input  logic [c8spr_pkg::ROW_W-1:0]      i_row_offset,
    input  logic [c8spr_pkg::BYTE_W-1:0]     i_row_byte,
    input  logic                             i_first_row,
    output logic                             o_strobe,
    output logic [c8spr_pkg::IDX_W-1:0]      o_cell_index,
    output logic [c8spr_pkg::VAL_W-1:0]      o_cell_value,
    output logic                             o_collision,
    output logic                             o_last
);

    c8spr_pkg::t_cmd cmd;
    c8spr_pkg::t_sta sta;

    // Sequencer: sweeps, then read / write per cell
    c8spr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_sta       (sta),
        .o_cmd       (cmd),
        .busy        (busy)
    );

    // Store, pixel lanes and result registers
    c8spr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sta        (sta),
        .i_x_position (i_x_position),
        .i_y_position (i_y_position),
        .i_row_offset (i_row_offset),
        .i_row_byte   (i_row_byte),
        .i_first_row  (i_first_row),
        .o_strobe     (o_strobe),
        .o_cell_index (o_cell_index),
        .o_cell_value (o_cell_value),
        .o_collision  (o_collision),
        .o_last       (o_last)
    );

endmodule

FILE: rtl/c8spr_dp.sv
// Datapath: cell store, pixel lanes, collision flag and result registers.
`timescale 1ns / 1ps

module c8spr_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  c8spr_pkg::t_cmd                  i_cmd,
    output c8spr_pkg::t_sta                  o_sta,
    input  logic [c8spr_pkg::POS_W-1:0]      i_x_position,
    input  logic [c8spr_pkg::POS_W-1:0]      i_y_position,
    input  logic [c8spr_pkg::ROW_W-1:0]      i_row_offset,
    input  logic [c8spr_pkg::BYTE_W-1:0]     i_row_byte,
    input  logic                             i_first_row,
    output logic                             o_strobe,
    output logic [c8spr_pkg::IDX_W-1:0]      o_cell_index,
    output logic [c8spr_pkg::VAL_W-1:0]      o_cell_value,
    output logic                             o_collision,
    output logic                             o_last
);

    localparam int XW = c8spr_pkg::X_W;
    localparam int YW = c8spr_pkg::Y_W;
    localparam int CW = c8spr_pkg::COL_W;
    localparam int AW = c8spr_pkg::CADDR_W;
    localparam int VW = c8spr_pkg::VAL_W;
    localparam int NP = c8spr_pkg::PIX_PER_ROW;

    // Cell store
    logic [VW-1:0] r_mem [c8spr_pkg::CELL_COUNT];
    logic [VW-1:0] r_rdata;

    logic [XW-1:0]                     r_x;
    logic [YW-1:0]                     r_py;
    logic [c8spr_pkg::BYTE_W-1:0]      r_rb;
    logic [CW-1:0]                     r_col;
    logic                              r_coll;
    logic [AW-1:0]                     r_sweep;

    logic                              r_strb;
    logic [c8spr_pkg::IDX_W-1:0]       r_idx;
    logic [VW-1:0]                     r_val;
    logic                              r_cflag;
    logic                              r_last;

    logic [XW-1:0]  x_in;
    logic [YW:0]    y_sum;
    logic [YW-1:0]  py_in;
    logic [XW:0]    px_sum [NP];
    logic [XW-1:0]  px     [NP];
    logic [CW-1:0]  pcol   [NP];
    logic [VW-1:0]  mask;
    logic [CW-1:0]  col_next;
    logic [AW-1:0]  rowbase;
    logic [AW-1:0]  addr_cur;
    logic [AW-1:0]  addr_nxt;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic [VW-1:0]  wr_data;
    logic           wr_en;
    logic [VW-1:0]  new_val;
    logic           hit;

    // Input folding: tables for the modulo, one wrap for the row offset
    always_comb begin
        x_in  = c8spr_pkg::XMOD_TAB[i_x_position];
        y_sum = {1'b0, c8spr_pkg::YMOD_TAB[i_y_position]} + (YW+1)'(i_row_offset);
        if (y_sum >= (YW+1)'(c8spr_pkg::SCREEN_HEIGHT)) begin
            py_in = YW'(y_sum - (YW+1)'(c8spr_pkg::SCREEN_HEIGHT));
        end else begin
            py_in = YW'(y_sum);
        end
    end

    // Eight pixel lanes: wrapped column and cell column of each pixel
    always_comb begin
        mask = '0;
        for (int i = 0; i < NP; i++) begin
            px_sum[i] = {1'b0, r_x} + (XW+1)'(i);
            if (px_sum[i] >= (XW+1)'(c8spr_pkg::SCREEN_WIDTH)) begin
                px[i] = XW'(px_sum[i] - (XW+1)'(c8spr_pkg::SCREEN_WIDTH));
            end else begin
                px[i] = XW'(px_sum[i]);
            end
            pcol[i] = CW'(px[i] >> 1);
            if (pcol[i] == r_col && r_rb[NP-1-i]) begin
                mask[{r_py[0], px[i][0]}] = 1'b1;
            end
        end
    end

    always_comb begin
        if (r_col == CW'(c8spr_pkg::CELL_COLS - 1)) begin
            col_next = '0;
        end else begin
            col_next = r_col + 1'b1;
        end
        rowbase  = AW'(r_py >> 1) * AW'(c8spr_pkg::CELL_COLS);
        addr_cur = rowbase + AW'(r_col);
        addr_nxt = rowbase + AW'(col_next);
        // read ahead to the next cell while the current one is written
        rd_addr  = i_cmd.wr_cell ? addr_nxt : addr_cur;
        new_val  = r_rdata ^ mask;
        hit      = |(r_rdata & mask);
        wr_en    = i_cmd.wr_cell | i_cmd.sweep;
        wr_addr  = i_cmd.sweep ? r_sweep : addr_cur;
        wr_data  = i_cmd.sweep ? '0 : new_val;
    end

    assign o_sta.last_cell  = (r_col == pcol[NP-1]);
    assign o_sta.sweep_done = (r_sweep == AW'(c8spr_pkg::CELL_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Draw word registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_draw) begin
            r_x  <= x_in;
            r_py <= py_in;
            r_rb <= i_row_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_draw) begin
            r_col <= CW'(x_in >> 1);
        end else if (i_cmd.wr_cell) begin
            r_col <= col_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coll  <= 1'b0;
            r_sweep <= '0;
        end else begin
            if (i_cmd.load_draw && i_first_row) begin
                r_coll <= 1'b0;
            end else if (i_cmd.wr_cell && hit) begin
                r_coll <= 1'b1;
            end
            if (i_cmd.load_clear) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep) begin
                r_sweep <= r_sweep + 1'b1;
            end
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strb <= 1'b0;
        end else begin
            r_strb <= i_cmd.load_clear | i_cmd.wr_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_clear) begin
            r_idx   <= '0;
            r_val   <= '0;
            r_cflag <= r_coll;
            r_last  <= 1'b1;
        end else if (i_cmd.wr_cell) begin
            r_idx   <= c8spr_pkg::IDX_W'(addr_cur);
            r_val   <= new_val;
            r_cflag <= r_coll | hit;
            r_last  <= o_sta.last_cell;
        end
    end

    assign o_strobe     = r_strb;
    assign o_cell_index = r_idx;
    assign o_cell_value = r_val;
    assign o_collision  = r_cflag;
    assign o_last       = r_last;

endmodule

FILE: rtl/c8spr_ctrl.sv
// Controller: sequences clear sweeps and per-cell read-modify-write.
`timescale 1ns / 1ps

module c8spr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            i_operation,
    input  c8spr_pkg::t_sta i_sta,
    output c8spr_pkg::t_cmd o_cmd,
    output logic            busy
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_sta.sweep_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == c8spr_pkg::OP_DRAW) begin
                        o_cmd.load_draw = 1'b1;
                        n_state         = S_READ;
                    end else begin
                        o_cmd.load_clear = 1'b1;
                        n_state          = S_CLEAR;
                    end
                end
            end
            S_READ: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr_cell = 1'b1;
                if (i_sta.last_cell) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: bench/tb.sv
// Self-checking bench for the packed-cell sprite XOR engine.
`timescale 1ns / 1ps

// The bench keeps a shadow copy of the 512-cell screen and of the collision
// flag. For every word that the block takes it predicts the cell writes that
// the word must cause and queues them. A checker pops one prediction per
// result strobe and compares it field by field.
//
// Test order: clear after reset, edge positions and wrap, collision
// behaviour, then a long random run of mostly well-formed sprites with some
// noise, broken sprites and clears mixed in.

module tb;

    // One predicted cell write
    typedef struct packed {
        logic [c8spr_pkg::IDX_W-1:0] index;
        logic [c8spr_pkg::VAL_W-1:0] value;
        logic                        collision;
        logic                        last;
    } t_cell_write;

    localparam int DRAIN_LIMIT = 2000;   // covers a clear sweep with margin
    localparam int TAIL_CYCLES = 20;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic                               i_operation;
    logic [c8spr_pkg::POS_W-1:0]        i_x_position;
    logic [c8spr_pkg::POS_W-1:0]        i_y_position;
    logic [c8spr_pkg::ROW_W-1:0]        i_row_offset;
    logic [c8spr_pkg::BYTE_W-1:0]       i_row_byte;
    logic                               i_first_row;
    logic                               o_strobe;
    logic [c8spr_pkg::IDX_W-1:0]        o_cell_index;
    logic [c8spr_pkg::VAL_W-1:0]        o_cell_value;
    logic                               o_collision;
    logic                               o_last;

    // Shadow screen and flag, updated as each word is taken
    logic [c8spr_pkg::VAL_W-1:0]        shadow_cells [c8spr_pkg::CELL_COUNT];
    logic                               shadow_collision;

    // Cell writes still owed by the block, oldest first
    t_cell_write                        pending_cells [$];

    int                                 mismatch_count = 0;
    int                                 words_sent     = 0;
    int                                 burst_left     = 0;

    // Row bytes of the sprite being drawn
    logic [c8spr_pkg::BYTE_W-1:0]       sprite_rows [16];

    chip8_sprite_xor_packed_cells u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_x_position (i_x_position),
        .i_y_position (i_y_position),
        .i_row_offset (i_row_offset),
        .i_row_byte   (i_row_byte),
        .i_first_row  (i_first_row),
        .o_strobe     (o_strobe),
        .o_cell_index (o_cell_index),
        .o_cell_value (o_cell_value),
        .o_collision  (o_collision),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Only the first ten failures get a line of their own
    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] %s", $realtime, what);
        end
    endtask

    // Work out the cell writes of one word and apply it to the shadow screen.
    function automatic void predict_word(input logic op,
                                         input logic [c8spr_pkg::POS_W-1:0] xp,
                                         input logic [c8spr_pkg::POS_W-1:0] yp,
                                         input logic [c8spr_pkg::ROW_W-1:0] ro,
                                         input logic [c8spr_pkg::BYTE_W-1:0] rb,
                                         input logic fr);
        int                          x;
        int                          line;
        int                          rowbase;
        int                          vshift;
        int                          px;
        int                          cell_no;
        int                          ncell;
        int                          cells [5];
        logic [c8spr_pkg::VAL_W-1:0] masks [5];
        logic [c8spr_pkg::VAL_W-1:0] old_val;
        t_cell_write                 w;
        if (op == c8spr_pkg::OP_CLEAR) begin
            // Clear leaves the collision flag alone and reports cell zero
            foreach (shadow_cells[i]) shadow_cells[i] = '0;
            w.index     = '0;
            w.value     = '0;
            w.collision = shadow_collision;
            w.last      = 1'b1;
            pending_cells.push_back(w);
        end else begin
            x       = int'(xp) % c8spr_pkg::SCREEN_WIDTH;
            line    = (int'(yp) + int'(ro)) % c8spr_pkg::SCREEN_HEIGHT;
            rowbase = (line / 2) * c8spr_pkg::CELL_COLS;
            vshift  = (line % 2) * 2;
            if (fr) shadow_collision = 1'b0;
            // Group the eight pixels, MSB first, into the cells they hit;
            // the wrap at the right edge starts a new cell at column zero.
            ncell = 0;
            for (int i = 0; i < c8spr_pkg::PIX_PER_ROW; i++) begin
                px      = (x + i) % c8spr_pkg::SCREEN_WIDTH;
                cell_no = rowbase + px / 2;
                if (ncell == 0 || cell_no != cells[ncell-1]) begin
                    cells[ncell] = cell_no;
                    masks[ncell] = '0;
                    ncell++;
                end
                if (rb[c8spr_pkg::PIX_PER_ROW-1-i]) masks[ncell-1][px % 2 + vshift] = 1'b1;
            end
            // Every covered cell is written, changed or not
            for (int k = 0; k < ncell; k++) begin
                old_val = shadow_cells[cells[k]];
                if ((old_val & masks[k]) != '0) shadow_collision = 1'b1;
                shadow_cells[cells[k]] = old_val ^ masks[k];
                w.index     = c8spr_pkg::IDX_W'(cells[k]);
                w.value     = shadow_cells[cells[k]];
                w.collision = shadow_collision;
                w.last      = (k == ncell - 1);
                pending_cells.push_back(w);
            end
        end
    endfunction

    // Sender pacing: bursts of random length, random gaps between them.
    // A gap of zero lets bursts run together.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Present one word and hold it until an edge with busy low takes it.
    // Start is left high so that back-to-back words need no extra step.
    task automatic send_word(input logic op,
                             input logic [c8spr_pkg::POS_W-1:0] xp,
                             input logic [c8spr_pkg::POS_W-1:0] yp,
                             input logic [c8spr_pkg::ROW_W-1:0] ro,
                             input logic [c8spr_pkg::BYTE_W-1:0] rb,
                             input logic fr);
        i_operation  <= op;
        i_x_position <= xp;
        i_y_position <= yp;
        i_row_offset <= ro;
        i_row_byte   <= rb;
        i_first_row  <= fr;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_word(op, xp, yp, ro, rb, fr);
        words_sent++;
        pace();
    endtask

    // Stop sending until every predicted write has been seen.
    // Always waits at least one edge so start is never re-driven in this step.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_cells.size() != 0);
    endtask

    // Draw the rows held in sprite_rows as one well-formed sprite
    task automatic draw_sprite(input logic [c8spr_pkg::POS_W-1:0] xp,
                               input logic [c8spr_pkg::POS_W-1:0] yp,
                               input int height);
        for (int r = 0; r < height; r++) begin
            send_word(c8spr_pkg::OP_DRAW, xp, yp, c8spr_pkg::ROW_W'(r), sprite_rows[r],
                      r == 0);
        end
    endtask

    // --- directed tests ---

    task automatic test_clear_after_reset();
        send_word(c8spr_pkg::OP_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1);
    endtask

    task automatic test_edges();
        send_word(c8spr_pkg::OP_DRAW, 8'd0,   8'd0,   4'd0,  8'hFF, 1'b1);  // top left
        send_word(c8spr_pkg::OP_DRAW, 8'd63,  8'd31,  4'd0,  8'hFF, 1'b1);  // odd x, wraps
        send_word(c8spr_pkg::OP_DRAW, 8'd62,  8'd1,   4'd0,  8'hA5, 1'b0);  // even x, wraps
        send_word(c8spr_pkg::OP_DRAW, 8'd255, 8'd255, 4'hF,  8'h81, 1'b1);  // both wrap
        send_word(c8spr_pkg::OP_DRAW, 8'd1,   8'd9,   4'd3,  8'h00, 1'b0);  // empty row
        send_word(c8spr_pkg::OP_DRAW, 8'd128, 8'd16,  4'd15, 8'h7E, 1'b0);  // x folds, bottom line
    endtask

    task automatic test_collision();
        send_word(c8spr_pkg::OP_DRAW, 8'd10, 8'd4,  4'd0, 8'hFF, 1'b1);
        send_word(c8spr_pkg::OP_DRAW, 8'd10, 8'd4,  4'd0, 8'hFF, 1'b1);  // erases: flag set
        send_word(c8spr_pkg::OP_DRAW, 8'd40, 8'd20, 4'd1, 8'h00, 1'b0);  // flag carried on
        send_word(c8spr_pkg::OP_CLEAR, 8'd0, 8'd0,  4'd0, 8'h00, 1'b0);  // clear keeps flag
        send_word(c8spr_pkg::OP_DRAW, 8'd40, 8'd20, 4'd0, 8'h3C, 1'b1);  // new sprite drops it
        send_word(c8spr_pkg::OP_DRAW, 8'd41, 8'd20, 4'd0, 8'h18, 1'b0);  // partial overlap
    endtask

    // --- random run ---

    task automatic test_random_sprites();
        int                          goal;
        int                          pick;
        int                          height;
        bit                          drained;
        logic [c8spr_pkg::POS_W-1:0] xp;
        logic [c8spr_pkg::POS_W-1:0] yp;
        goal    = words_sent + 145;
        drained = 1'b0;
        while (words_sent < goal) begin
            pick = $urandom_range(0, 99);
            xp   = c8spr_pkg::POS_W'($urandom_range(0, 255));
            yp   = c8spr_pkg::POS_W'($urandom_range(0, 255));
            if (pick < 4) begin
                // Clears are slow (full sweep), so keep them rare
                send_word(c8spr_pkg::OP_CLEAR, xp, yp,
                          c8spr_pkg::ROW_W'($urandom_range(0, 15)),
                          c8spr_pkg::BYTE_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end else if (pick < 14) begin
                // Noise: lone row with arbitrary offset and flag
                send_word(c8spr_pkg::OP_DRAW, xp, yp,
                          c8spr_pkg::ROW_W'($urandom_range(0, 15)),
                          c8spr_pkg::BYTE_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end else if (pick < 22) begin
                // Broken sprite: offsets out of order, first-row flag anywhere
                height = $urandom_range(2, 5);
                for (int r = 0; r < height; r++) begin
                    send_word(c8spr_pkg::OP_DRAW, xp, yp,
                              c8spr_pkg::ROW_W'($urandom_range(0, 15)),
                              c8spr_pkg::BYTE_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                end
            end else begin
                // Well-formed sprite, mostly short; sometimes drawn twice to erase
                height = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                     : $urandom_range(1, 5);
                foreach (sprite_rows[r]) begin
                    sprite_rows[r] = c8spr_pkg::BYTE_W'($urandom_range(0, 255));
                end
                draw_sprite(xp, yp, height);
                if ($urandom_range(0, 2) == 0) draw_sprite(xp, yp, height);
            end
            // Let the pipeline empty once mid-run
            if (!drained && words_sent > goal - 80) begin
                wait_drained();
                drained = 1'b1;
            end
        end
    endtask

    // Result checker: one strobe, one prediction
    always @(posedge i_clk) begin
        t_cell_write want;
        if (i_rst_n && o_strobe) begin
            if (pending_cells.size() == 0) begin
                log_mismatch($sformatf("unexpected write idx=%0d val=%h col=%b last=%b",
                                       o_cell_index, o_cell_value, o_collision, o_last));
            end else begin
                want = pending_cells.pop_front();
                if (o_cell_index !== want.index || o_cell_value !== want.value ||
                    o_collision !== want.collision || o_last !== want.last) begin
                    log_mismatch($sformatf({"write mismatch: exp idx=%0d val=%h col=%b",
                                            " last=%b, got idx=%0d val=%h col=%b last=%b"},
                                           want.index, want.value, want.collision,
                                           want.last, o_cell_index, o_cell_value,
                                           o_collision, o_last));
                end
            end
        end
    end

    initial begin
        int wait_cnt;
        foreach (shadow_cells[i]) shadow_cells[i] = '0;
        shadow_collision = 1'b0;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_operation  <= c8spr_pkg::OP_CLEAR;
        i_x_position <= '0;
        i_y_position <= '0;
        i_row_offset <= '0;
        i_row_byte   <= '0;
        i_first_row  <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The block sweeps its store after reset; send_word waits on busy
        test_clear_after_reset();
        test_edges();
        wait_drained();
        test_collision();
        wait_drained();
        test_random_sprites();

        start <= 1'b0;
        wait_cnt = 0;
        while (pending_cells.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        if (pending_cells.size() != 0) begin
            log_mismatch($sformatf("%0d predicted writes never arrived",
                                   pending_cells.size()));
        end
        // Catch any stray strobes after the last expected write
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/c8spr_pkg.sv
rtl/c8spr_dp.sv
rtl/c8spr_ctrl.sv
rtl/chip8_sprite_xor_packed_cells.sv
bench/tb.sv
